/* src/yfdtd_pkg.sv */
// Shared types, codes and constants for the 2D Yee field update core.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps
`default_nettype none

package yfdtd_pkg;

  // Default lattice size, without the halo
  localparam int NX_DEF = 16;
  localparam int NY_DEF = 16;

  // Field widths
  localparam int COEFF_W = 18;
  localparam int VAL_W   = 32;
  localparam int SEL_W   = 4;
  localparam int IDX_W   = 6;
  localparam int OP_W    = 3;
  // Sum of four signed 32-bit values
  localparam int DIFF_W  = 34;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  // Item opcodes
  localparam logic [OP_W-1:0] OP_WRITE   = 3'd0;
  localparam logic [OP_W-1:0] OP_READ    = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_E  = 3'd2;
  localparam logic [OP_W-1:0] OP_PUSH_B  = 3'd3;
  localparam logic [OP_W-1:0] OP_DEPOSIT = 3'd4;

  // Array selects that bound each store group
  localparam logic [SEL_W-1:0] SEL_FIRST_B = 4'd3;
  localparam logic [SEL_W-1:0] SEL_FIRST_J = 4'd6;
  localparam logic [SEL_W-1:0] SEL_LAST    = 4'd8;

  // Store groups
  localparam logic [1:0] GRP_E = 2'd0;
  localparam logic [1:0] GRP_B = 2'd1;
  localparam logic [1:0] GRP_J = 2'd2;

  typedef enum logic [1:0] {
    WALK_E,
    WALK_B,
    WALK_DEP
  } walk_t;

  // One source read of the per-cell stencil: component, column and row
  // offset (biased by one), target difference and sign
  typedef struct packed {
    logic       en;
    logic [1:0] comp;
    logic [1:0] ox;
    logic [1:0] oy;
    logic [1:0] tgt;
    logic       neg;
  } tap_t;

  localparam tap_t TAPS_E [8] = '{
    '{1'b1, 2'd2, 2'd1, 2'd1, 2'd0, 1'b0},
    '{1'b1, 2'd2, 2'd1, 2'd0, 2'd0, 1'b1},
    '{1'b1, 2'd2, 2'd0, 2'd1, 2'd1, 1'b0},
    '{1'b1, 2'd2, 2'd1, 2'd1, 2'd1, 1'b1},
    '{1'b1, 2'd0, 2'd1, 2'd0, 2'd2, 1'b0},
    '{1'b1, 2'd0, 2'd1, 2'd1, 2'd2, 1'b1},
    '{1'b1, 2'd1, 2'd1, 2'd1, 2'd2, 1'b0},
    '{1'b1, 2'd1, 2'd0, 2'd1, 2'd2, 1'b1}
  };

  localparam tap_t TAPS_B [8] = '{
    '{1'b1, 2'd2, 2'd1, 2'd1, 2'd0, 1'b0},
    '{1'b1, 2'd2, 2'd1, 2'd2, 2'd0, 1'b1},
    '{1'b1, 2'd2, 2'd2, 2'd1, 2'd1, 1'b0},
    '{1'b1, 2'd2, 2'd1, 2'd1, 2'd1, 1'b1},
    '{1'b1, 2'd0, 2'd1, 2'd2, 2'd2, 1'b0},
    '{1'b1, 2'd0, 2'd1, 2'd1, 2'd2, 1'b1},
    '{1'b1, 2'd1, 2'd1, 2'd1, 2'd2, 1'b0},
    '{1'b1, 2'd1, 2'd2, 2'd1, 2'd2, 1'b1}
  };

  localparam tap_t TAPS_DEP [8] = '{
    '{1'b1, 2'd0, 2'd1, 2'd1, 2'd0, 1'b1},
    '{1'b1, 2'd1, 2'd1, 2'd1, 2'd1, 1'b1},
    '{1'b1, 2'd2, 2'd1, 2'd1, 2'd2, 1'b1},
    '{1'b0, 2'd0, 2'd1, 2'd1, 2'd0, 1'b0},
    '{1'b0, 2'd0, 2'd1, 2'd1, 2'd0, 1'b0},
    '{1'b0, 2'd0, 2'd1, 2'd1, 2'd0, 1'b0},
    '{1'b0, 2'd0, 2'd1, 2'd1, 2'd0, 1'b0},
    '{1'b0, 2'd0, 2'd1, 2'd1, 2'd0, 1'b0}
  };

  function automatic tap_t tap_lookup(input walk_t w, input logic [2:0] idx);
    tap_t t;
    case (w)
      WALK_E:   t = TAPS_E[idx];
      WALK_B:   t = TAPS_B[idx];
      WALK_DEP: t = TAPS_DEP[idx];
      default:  t = TAPS_DEP[idx];
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

/* src/yfdtd_if.sv */
// Handshake channels of the field update core: item in, result out, config.
// Depends on yfdtd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface yfdtd_item_if import yfdtd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic [SEL_W-1:0]         array_select;
  logic signed [IDX_W-1:0]  x_index;
  logic signed [IDX_W-1:0]  y_index;
  logic signed [VAL_W-1:0]  write_value;

  modport source (output valid, opcode, array_select, x_index, y_index, write_value,
                  input ready);
  modport sink (input valid, opcode, array_select, x_index, y_index, write_value,
                output ready);
endinterface

interface yfdtd_result_if import yfdtd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  read_value;
  logic                     overflow_seen;
  logic                     bad_index;

  modport source (output valid, read_value, overflow_seen, bad_index, input ready);
  modport sink (input valid, read_value, overflow_seen, bad_index, output ready);
endinterface

interface yfdtd_cfg_if import yfdtd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COEFF_W-1:0] courant_coeff;

  modport source (output valid, courant_coeff, input ready);
  modport sink (input valid, courant_coeff, output ready);
endinterface

`default_nettype wire

/* src/yfdtd_store.sv */
// One field store: three planes of cells, one write and one registered read port.
// Depends on yfdtd_pkg for the word width.
`timescale 1ns / 1ps
`default_nettype none

module yfdtd_store import yfdtd_pkg::*; #(
  parameter int DEPTH = 972,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [VAL_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [DEPTH];

  // Write and read one word a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/yfdtd_mac.sv */
// Shared update unit: multiply by the coefficient, round, add and saturate.
// Depends on yfdtd_pkg for widths and saturation limits.
`timescale 1ns / 1ps
`default_nettype none

module yfdtd_mac import yfdtd_pkg::*; (
  input  logic                     clk,
  input  logic                     mul_en,
  input  logic [COEFF_W-1:0]       coeff,
  input  logic signed [DIFF_W-1:0] diff,
  input  logic                     half,
  input  logic                     direct,
  input  logic signed [VAL_W-1:0]  old_val,
  output logic signed [VAL_W-1:0]  sum,
  output logic                     sat
);

  localparam int PW = DIFF_W + COEFF_W + 1;
  localparam int SW = PW + 1 - 16;
  localparam logic signed [PW:0] BIAS_FULL = (PW+1)'(32768);
  localparam logic signed [PW:0] BIAS_HALF = (PW+1)'(65536);
  localparam logic signed [SW:0] SUM_MAX = (SW+1)'(VAL_MAX);
  localparam logic signed [SW:0] SUM_MIN = (SW+1)'(VAL_MIN);

  logic signed [PW-1:0] prod;
  logic signed [PW:0]   rnd;
  logic signed [PW:0]   shifted;
  logic signed [SW-1:0] scaled;
  logic signed [SW:0]   sum_w;

  // Stage one: product of coefficient and difference
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= $signed({1'b0, coeff}) * diff;
    end
  end

  // Round half up and drop the fraction bits
  always_comb begin
    rnd     = (PW+1)'(prod) + (half ? BIAS_HALF : BIAS_FULL);
    shifted = half ? (rnd >>> 17) : (rnd >>> 16);
  end

  // Stage two: the increment, or the difference itself for a deposit
  always_ff @(posedge clk) begin
    scaled <= direct ? SW'(diff) : SW'(shifted);
  end

  // Add to the old value and clamp to 32 bits
  always_comb begin
    sum_w = (SW+1)'(old_val) + (SW+1)'(scaled);
    sat   = (sum_w > SUM_MAX) || (sum_w < SUM_MIN);
    if (sum_w > SUM_MAX) begin
      sum = VAL_MAX;
    end else if (sum_w < SUM_MIN) begin
      sum = VAL_MIN;
    end else begin
      sum = VAL_W'(sum_w);
    end
  end

endmodule

`default_nettype wire

/* src/yee_fdtd_2d_field_update_core.sv */
// 2D Yee lattice field update core: nine field planes with a one-cell halo.
// Uses the item, result and config channels (yfdtd_if) and one shared
// update unit (yfdtd_mac) over three stores (yfdtd_store).
//
// Each accepted item on "item" gives exactly one word on "result".
// Write, bad-index, unknown-array and unknown-opcode items load the result
// register directly at acceptance. A read goes through the registered store
// read port and the S_RDATA state before the result register is loaded.
// Push E, push half B and deposit walk all NX*NY interior cells. Each cell
// first gathers its stencil reads through the single source read port, then
// takes each component in turn through the shared multiplier (issue
// multiply and old-value read, round, add and write back). item.ready stays
// low while a walk runs.
// item.ready is high when idle and the result register is free or draining.
// A stalled result holds its word; no new item is taken until it leaves.
// The config channel writes courant_coeff and is always ready; write it
// only while idle. Reset clears the coefficient, the sticky overflow flag
// and the control state; store contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module yee_fdtd_2d_field_update_core import yfdtd_pkg::*; #(
  parameter int NX = NX_DEF,
  parameter int NY = NY_DEF
) (
  input  logic             clk,
  input  logic             rst,
  yfdtd_item_if.sink       item,
  yfdtd_result_if.source   result,
  yfdtd_cfg_if.sink        cfg
);

  localparam int ROW   = NX + 2;
  localparam int PLANE = ROW * (NY + 2);
  localparam int DEPTH = 3 * PLANE;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(NX + 1);
  localparam int YW    = $clog2(NY + 1);
  localparam logic signed [9:0] NX_S = 10'(NX);
  localparam logic signed [9:0] NY_S = 10'(NY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDATA,
    S_SRC,
    S_UPD,
    S_FIN
  } state_t;

  state_t              state;
  walk_t               walk;
  logic [XW-1:0]       cx;
  logic [YW-1:0]       cy;
  logic [3:0]          step;
  logic [1:0]          sub;
  logic [1:0]          comp;
  logic [1:0]          rd_grp;
  logic signed [DIFF_W-1:0] d [3];
  logic [COEFF_W-1:0]  coeff;
  logic                ovf;

  logic                accept;
  logic                out_free;
  logic                res_load;
  logic signed [9:0]   xw;
  logic signed [9:0]   yw;
  logic                bad;
  logic [1:0]          grp;
  logic [1:0]          hcomp;
  logic                sel_ok;
  logic [AW-1:0]       host_addr;
  tap_t                tap_rd;
  tap_t                tap_acc;
  logic [1:0]          src_grp;
  logic [1:0]          dst_grp;
  logic [1:0]          use_grp;
  logic [AW-1:0]       walk_addr;
  logic [AW-1:0]       dst_addr;

  logic [2:0]          st_we;
  logic [2:0]          st_re;
  logic [AW-1:0]       raddr;
  logic [AW-1:0]       waddr;
  logic [VAL_W-1:0]    wdata;
  logic [VAL_W-1:0]    rdata [3];
  logic signed [VAL_W-1:0] cur_rdata;

  logic signed [VAL_W-1:0] mac_sum;
  logic                mac_sat;

  function automatic logic [AW-1:0] cell_addr(input logic [1:0] c,
                                              input logic [AW-1:0] col,
                                              input logic [AW-1:0] row);
    return AW'(int'(c) * PLANE + int'(row) * ROW + int'(col));
  endfunction

  assign out_free  = !result.valid || result.ready;
  assign item.ready = (state == S_IDLE) && out_free;
  assign accept    = item.valid && item.ready;
  assign cfg.ready = 1'b1;

  // Decode the host cell index and array select
  always_comb begin
    xw     = 10'(item.x_index);
    yw     = 10'(item.y_index);
    bad    = (xw < -10'sd1) || (xw > NX_S) || (yw < -10'sd1) || (yw > NY_S);
    sel_ok = (item.array_select <= SEL_LAST);
    if (item.array_select < SEL_FIRST_B) begin
      grp   = GRP_E;
      hcomp = item.array_select[1:0];
    end else if (item.array_select < SEL_FIRST_J) begin
      grp   = GRP_B;
      hcomp = 2'(item.array_select - SEL_FIRST_B);
    end else begin
      grp   = GRP_J;
      hcomp = 2'(item.array_select - SEL_FIRST_J);
    end
    host_addr = cell_addr(hcomp, AW'(xw + 10'sd1), AW'(yw + 10'sd1));
  end

  // Flag the cycles that load a new result word
  always_comb begin
    res_load = 1'b0;
    case (state)
      S_IDLE: begin
        res_load = accept && (item.opcode != OP_PUSH_E) && (item.opcode != OP_PUSH_B)
                   && (item.opcode != OP_DEPOSIT)
                   && !(item.opcode == OP_READ && !bad && sel_ok);
      end
      S_RDATA: begin
        res_load = 1'b1;
      end
      S_FIN: begin
        res_load = out_free;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // Walk source and destination stores and addresses
  always_comb begin
    case (walk)
      WALK_E:   begin src_grp = GRP_B; dst_grp = GRP_E; end
      WALK_B:   begin src_grp = GRP_E; dst_grp = GRP_B; end
      WALK_DEP: begin src_grp = GRP_J; dst_grp = GRP_E; end
      default:  begin src_grp = GRP_J; dst_grp = GRP_E; end
    endcase
    tap_rd    = tap_lookup(walk, step[2:0]);
    tap_acc   = tap_lookup(walk, 3'(step - 4'd1));
    walk_addr = cell_addr(tap_rd.comp, AW'(cx) + AW'(tap_rd.ox),
                          AW'(cy) + AW'(tap_rd.oy));
    dst_addr  = cell_addr(comp, AW'(cx) + AW'(1), AW'(cy) + AW'(1));
    case (state)
      S_RDATA: use_grp = rd_grp;
      S_SRC:   use_grp = src_grp;
      default: use_grp = dst_grp;
    endcase
    cur_rdata = $signed(rdata[use_grp]);
  end

  // Drive the store ports
  always_comb begin
    st_we = '0;
    st_re = '0;
    raddr = host_addr;
    waddr = host_addr;
    wdata = item.write_value;
    case (state)
      S_IDLE: begin
        if (accept && !bad && sel_ok) begin
          if (item.opcode == OP_WRITE) begin
            st_we[grp] = 1'b1;
          end else if (item.opcode == OP_READ) begin
            st_re[grp] = 1'b1;
          end
        end
      end
      S_SRC: begin
        raddr = walk_addr;
        if (step[3] == 1'b0 && tap_rd.en) begin
          st_re[src_grp] = 1'b1;
        end
      end
      S_UPD: begin
        raddr = dst_addr;
        waddr = dst_addr;
        wdata = mac_sum;
        if (sub == 2'd0) begin
          st_re[dst_grp] = 1'b1;
        end
        if (sub == 2'd2) begin
          st_we[dst_grp] = 1'b1;
        end
      end
      default: begin
        st_we = '0;
      end
    endcase
  end

  for (genvar g = 0; g < 3; g++) begin : g_store
    yfdtd_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
    ) u_store (
      .clk   (clk),
      .we    (st_we[g]),
      .waddr (waddr),
      .wdata (wdata),
      .re    (st_re[g]),
      .raddr (raddr),
      .rdata (rdata[g])
    );
  end

  yfdtd_mac u_mac (
    .clk     (clk),
    .mul_en  ((state == S_UPD) && (sub == 2'd0)),
    .coeff   (coeff),
    .diff    (d[comp]),
    .half    (walk == WALK_B),
    .direct  (walk == WALK_DEP),
    .old_val (cur_rdata),
    .sum     (mac_sum),
    .sat     (mac_sat)
  );

  // Sequencer, coefficient, sticky flag and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      coeff         <= '0;
      ovf           <= 1'b0;
      result.valid  <= 1'b0;
      step          <= '0;
      sub           <= '0;
      comp          <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        coeff <= cfg.courant_coeff;
      end
      if (result.valid && result.ready && !res_load) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cx   <= '0;
            cy   <= '0;
            step <= '0;
            sub  <= '0;
            comp <= '0;
            case (item.opcode)
              OP_WRITE, OP_READ: begin
                if (!bad && sel_ok && item.opcode == OP_READ) begin
                  rd_grp <= grp;
                  state  <= S_RDATA;
                end else begin
                  result.valid         <= 1'b1;
                  result.read_value    <= '0;
                  result.overflow_seen <= ovf;
                  result.bad_index     <= bad;
                end
              end
              OP_PUSH_E: begin
                walk  <= WALK_E;
                state <= S_SRC;
              end
              OP_PUSH_B: begin
                walk  <= WALK_B;
                state <= S_SRC;
              end
              OP_DEPOSIT: begin
                walk  <= WALK_DEP;
                state <= S_SRC;
              end
              default: begin
                result.valid         <= 1'b1;
                result.read_value    <= '0;
                result.overflow_seen <= ovf;
                result.bad_index     <= 1'b0;
              end
            endcase
          end
        end
        S_RDATA: begin
          result.valid         <= 1'b1;
          result.read_value    <= cur_rdata;
          result.overflow_seen <= ovf;
          result.bad_index     <= 1'b0;
          state                <= S_IDLE;
        end
        S_SRC: begin
          // Clear, then gather the stencil differences
          if (step == 4'd0) begin
            d[0] <= '0;
            d[1] <= '0;
            d[2] <= '0;
          end else if (tap_acc.en) begin
            if (tap_acc.neg) begin
              d[tap_acc.tgt] <= d[tap_acc.tgt] - DIFF_W'(cur_rdata);
            end else begin
              d[tap_acc.tgt] <= d[tap_acc.tgt] + DIFF_W'(cur_rdata);
            end
          end
          if (step == 4'd8) begin
            state <= S_UPD;
            sub   <= '0;
            comp  <= '0;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_UPD: begin
          if (sub == 2'd2) begin
            sub <= '0;
            if (mac_sat) begin
              ovf <= 1'b1;
            end
            if (comp == 2'd2) begin
              comp <= '0;
              step <= '0;
              // Advance to the next interior cell
              if (cx == XW'(NX - 1)) begin
                cx <= '0;
                if (cy == YW'(NY - 1)) begin
                  state <= S_FIN;
                end else begin
                  cy    <= cy + YW'(1);
                  state <= S_SRC;
                end
              end else begin
                cx    <= cx + XW'(1);
                state <= S_SRC;
              end
            end else begin
              comp <= comp + 2'd1;
            end
          end else begin
            sub <= sub + 2'd1;
          end
        end
        S_FIN: begin
          if (out_free) begin
            result.valid         <= 1'b1;
            result.read_value    <= '0;
            result.overflow_seen <= ovf;
            result.bad_index     <= 1'b0;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Sticky flag never falls outside reset
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst) ovf |=> ovf)
    else $error("overflow flag cleared");

  // At most one store written per cycle
  a_one_write: assert property (@(posedge clk) disable iff (rst) $onehot0(st_we))
    else $error("more than one store written");

  // Walk writes only in the write-back slot
  a_wb_slot: assert property (@(posedge clk) disable iff (rst)
    ((|st_we) && state != S_IDLE) |-> (state == S_UPD && sub == 2'd2))
    else $error("store write outside write-back slot");

  // A read result finds the result register empty
  a_rdata_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDATA) |-> !result.valid)
    else $error("read result would overwrite pending word");

endmodule

`default_nettype wire

/* bench/tb_field_scoreboard.sv */
// Field scoreboard for the 2D Yee field update core bench: predicts each result
// word from its own copy of the nine planes, and checks the words that come back.
// Depends on yfdtd_pkg for the opcode and array-select codes.
`timescale 1ns / 1ps

package tb_field_pkg;
  import yfdtd_pkg::*;

  localparam int ROW = NX_DEF + 2;
  localparam int PLANE_CELLS = (NX_DEF + 2) * (NY_DEF + 2);
  localparam int NUM_ARRAYS = 9;

  class field_scoreboard;
    typedef struct {
      logic signed [VAL_W-1:0] rv;
      logic                    ov;
      logic                    bad;
    } word_t;

    int     fld [NUM_ARRAYS][PLANE_CELLS];
    bit     ovf;
    int     coeff;
    word_t  pending_q[$];
    int     errors;
    int     checked;
    int     walks;

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function int addr(int x, int y);
      return (y + 1) * ROW + (x + 1);
    endfunction

    function longint cell_val(int a, int x, int y);
      return longint'(fld[a][addr(x, y)]);
    endfunction

    // Clamp to the signed 32-bit range; set the sticky flag on a clip
    function int sat(longint v);
      if (v > 64'sd2147483647) begin
        ovf = 1;
        return VAL_MAX;
      end
      if (v < -64'sd2147483648) begin
        ovf = 1;
        return VAL_MIN;
      end
      return int'(v);
    endfunction

    // c*d / 2^s, rounding half up
    function longint scaled(longint d, int s);
      longint p;
      p = longint'(coeff) * d + (longint'(1) <<< (s - 1));
      return p >>> s;
    endfunction

    function void add_to(int a, int x, int y, longint delta);
      fld[a][addr(x, y)] = sat(cell_val(a, x, y) + delta);
    endfunction

    function void push_e();
      longint dx, dy, dz;
      for (int y = 0; y < NY_DEF; y++) begin
        for (int x = 0; x < NX_DEF; x++) begin
          dx = cell_val(5, x, y) - cell_val(5, x, y - 1);
          dy = cell_val(5, x - 1, y) - cell_val(5, x, y);
          dz = cell_val(3, x, y - 1) - cell_val(3, x, y)
             + cell_val(4, x, y) - cell_val(4, x - 1, y);
          add_to(0, x, y, scaled(dx, 16));
          add_to(1, x, y, scaled(dy, 16));
          add_to(2, x, y, scaled(dz, 16));
        end
      end
    endfunction

    function void push_half_b();
      longint dx, dy, dz;
      for (int y = 0; y < NY_DEF; y++) begin
        for (int x = 0; x < NX_DEF; x++) begin
          dx = cell_val(2, x, y) - cell_val(2, x, y + 1);
          dy = cell_val(2, x + 1, y) - cell_val(2, x, y);
          dz = cell_val(0, x, y + 1) - cell_val(0, x, y)
             + cell_val(1, x, y) - cell_val(1, x + 1, y);
          add_to(3, x, y, scaled(dx, 17));
          add_to(4, x, y, scaled(dy, 17));
          add_to(5, x, y, scaled(dz, 17));
        end
      end
    endfunction

    function void deposit();
      for (int c = 0; c < 3; c++)
        for (int y = 0; y < NY_DEF; y++)
          for (int x = 0; x < NX_DEF; x++)
            add_to(c, x, y, -cell_val(c + 6, x, y));
    endfunction

    // Update the lattice copy for one accepted word and queue its result
    function void note_item(logic [OP_W-1:0] op, logic [SEL_W-1:0] sel, int x, int y,
                            logic signed [VAL_W-1:0] wv);
      word_t w;
      w.rv = '0;
      w.bad = 1'b0;
      if (op == OP_WRITE || op == OP_READ) begin
        if (x < -1 || x > NX_DEF || y < -1 || y > NY_DEF) begin
          w.bad = 1'b1;
        end else if (sel <= SEL_LAST) begin
          if (op == OP_WRITE) fld[sel][addr(x, y)] = wv;
          else w.rv = fld[sel][addr(x, y)];
        end
      end else if (op == OP_PUSH_E) begin
        push_e();
        walks++;
      end else if (op == OP_PUSH_B) begin
        push_half_b();
        walks++;
      end else if (op == OP_DEPOSIT) begin
        deposit();
        walks++;
      end
      w.ov = ovf;
      pending_q = {pending_q, w};
    endfunction

    task check_result(logic signed [VAL_W-1:0] rv, logic ov, logic bad);
      word_t w;
      checked++;
      if (pending_q.size() == 0) begin
        report($sformatf("result word with none expected: rv=%h ov=%b bad=%b", rv, ov, bad));
        return;
      end
      w = pending_q.pop_front();
      if (rv !== w.rv)
        report($sformatf("read_value %h, expected %h", rv, w.rv));
      if (ov !== w.ov)
        report($sformatf("overflow_seen %b, expected %b", ov, w.ov));
      if (bad !== w.bad)
        report($sformatf("bad_index %b, expected %b", bad, w.bad));
    endtask
  endclass
endpackage

/* bench/tb_top.sv */
// Top of the field update core bench: clock, reset, item and config drivers,
// result stall and monitor. Depends on yfdtd_pkg, yfdtd_if and tb_field_pkg.
`timescale 1ns / 1ps

module tb_top;
  import yfdtd_pkg::*;
  import tb_field_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;
  localparam logic [SEL_W-1:0] SEL_EX = 4'd0;
  localparam logic [SEL_W-1:0] SEL_BX = 4'd3;
  localparam logic [SEL_W-1:0] SEL_BZ = 4'd5;
  localparam logic [SEL_W-1:0] SEL_UNKNOWN = 4'd9;
  localparam logic [SEL_W-1:0] SEL_MAX_CODE = 4'd15;
  localparam int COEFF_TOP = 262143;
  localparam int COEFF_ONE = 65536;

  logic clk = 1'b0;
  logic rst = 1'b1;

  yfdtd_item_if   item_ch();
  yfdtd_result_if result_ch();
  yfdtd_cfg_if    cfg_ch();

  yee_fdtd_2d_field_update_core dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  field_scoreboard sb = new();
  bit gaps_on = 1'b1;
  int coeffs_used = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result channel in random bursts while gaps are on
  initial begin
    int stall_left;
    stall_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Check every result word taken
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result(result_ch.read_value, result_ch.overflow_seen, result_ch.bad_index);
  end

  // Send one item word; hold it until taken
  task automatic send_item(logic [OP_W-1:0] op, logic [SEL_W-1:0] sel, int x, int y,
                           logic signed [VAL_W-1:0] wv);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.opcode       <= op;
    item_ch.array_select <= sel;
    item_ch.x_index      <= x[IDX_W-1:0];
    item_ch.y_index      <= y[IDX_W-1:0];
    item_ch.write_value  <= wv;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sb.note_item(op, sel, x, y, wv);
  endtask

  // Wait for all results, then write the coefficient
  task automatic set_coeff(int value);
    item_ch.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.courant_coeff <= value[COEFF_W-1:0];
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sb.coeff = value;
    coeffs_used++;
  endtask

  function automatic logic signed [VAL_W-1:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
    if (r == 7) return ($urandom_range(0, 1) == 0) ? VAL_MAX : VAL_MIN;
    return $urandom;
  endfunction

  function automatic int rand_in_range();
    return $urandom_range(0, NX_DEF + 1) - 1;
  endfunction

  // One random item: mostly well-formed accesses, a few walks, some noise
  task automatic random_item();
    int r;
    logic [OP_W-1:0] op;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_item(OP_WRITE, SEL_W'($urandom_range(0, SEL_LAST)), rand_in_range(),
                rand_in_range(), rand_value());
    end else if (r < 85) begin
      send_item(OP_READ, SEL_W'($urandom_range(0, SEL_LAST)), rand_in_range(),
                rand_in_range(), $urandom);
    end else if (r < 87) begin
      send_item(OP_PUSH_E, SEL_W'($urandom), $urandom_range(0, 63) - 32, 0, $urandom);
    end else if (r < 89) begin
      send_item(OP_PUSH_B, SEL_W'($urandom), 0, $urandom_range(0, 63) - 32, $urandom);
    end else if (r < 90) begin
      send_item(OP_DEPOSIT, SEL_W'($urandom), 0, 0, $urandom);
    end else if (r < 95) begin
      // raw index bits, often outside the lattice
      op = OP_W'($urandom_range(0, 1));
      send_item(op, SEL_W'($urandom_range(0, SEL_LAST)), $urandom_range(0, 63) - 32,
                $urandom_range(0, 63) - 32, $urandom);
    end else if (r < 98) begin
      op = OP_W'($urandom_range(0, 1));
      send_item(op, SEL_W'($urandom_range(SEL_LAST + 1, SEL_MAX_CODE)), rand_in_range(),
                rand_in_range(), $urandom);
    end else begin
      send_item(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), SEL_W'($urandom), 0, 0,
                $urandom);
    end
  endtask

  initial begin
    int phase_coeff [5];
    item_ch.valid        <= 1'b0;
    item_ch.opcode       <= OP_READ;
    item_ch.array_select <= SEL_EX;
    item_ch.x_index      <= '0;
    item_ch.y_index      <= '0;
    item_ch.write_value  <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.courant_coeff <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_coeff(COEFF_ONE);

    // Fill every cell of every plane so nothing unwritten is ever read
    for (int a = 0; a <= SEL_LAST; a++)
      for (int y = -1; y <= NY_DEF; y++)
        for (int x = -1; x <= NX_DEF; x++)
          send_item(OP_WRITE, SEL_W'(a), x, y, rand_value());

    // Directed: corners, extremes, bad indexes, unknown arrays and opcodes, then one walk of each kind
    send_item(OP_WRITE, SEL_EX, -1, -1, VAL_MAX);
    send_item(OP_READ,  SEL_EX, -1, -1, '0);
    send_item(OP_WRITE, SEL_LAST, NX_DEF, NY_DEF, VAL_MIN);
    send_item(OP_READ,  SEL_LAST, NX_DEF, NY_DEF, '1);
    send_item(OP_WRITE, SEL_BZ, NX_DEF + 1, 0, 32'sh1234_5678);
    send_item(OP_READ,  SEL_BZ, -2, 0, '0);
    send_item(OP_READ,  SEL_BX, 0, -32, '0);
    send_item(OP_WRITE, SEL_BX, 31, 31, '1);
    send_item(OP_READ,  SEL_BX, 0, NY_DEF + 1, '0);
    send_item(OP_WRITE, SEL_UNKNOWN, 0, 0, 32'sh5555_AAAA);
    send_item(OP_READ,  SEL_MAX_CODE, 3, 3, '0);
    send_item(OP_SPARE_LO, SEL_EX, 0, 0, '0);
    send_item(OP_SPARE_MID, SEL_EX, 0, 0, '0);
    send_item(OP_SPARE_HI, SEL_MAX_CODE, -32, 31, '1);
    send_item(OP_PUSH_E, SEL_EX, 0, 0, '0);
    send_item(OP_PUSH_B, SEL_EX, 0, 0, '0);
    send_item(OP_DEPOSIT, SEL_EX, 0, 0, '0);
    send_item(OP_READ, SEL_EX, 0, 0, '0);
    send_item(OP_READ, SEL_BZ, NX_DEF - 1, NY_DEF - 1, '0);

    // Random phases over several coefficients, the extremes among them
    phase_coeff = '{0, COEFF_TOP, COEFF_ONE, $urandom_range(1, COEFF_TOP - 1), 1};
    for (int p = 0; p < 5; p++) begin
      set_coeff(phase_coeff[p]);
      if (p == 4) gaps_on = 1'b0;
      repeat (250) random_item();
    end
    item_ch.valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d result words, %0d lattice walks, %0d coefficient settings.",
             sb.checked, sb.walks, coeffs_used);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #20ms;
    $display("Timeout with %0d result words still expected", sb.pending_q.size());
    $display("CHECK FAILED");
    $finish;
  end
endmodule

/* filelist.f */
src/yfdtd_pkg.sv
src/yfdtd_if.sv
src/yfdtd_store.sv
src/yfdtd_mac.sv
src/yee_fdtd_2d_field_update_core.sv
bench/tb_field_scoreboard.sv
bench/tb_top.sv
